@@ design/tlrpq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tlrpq_pkg;

   localparam logic [3:0]  KIND_IDLE          = 4'd0;
   localparam logic [3:0]  KIND_SHUTDOWN      = 4'd1;
   localparam logic [3:0]  KIND_WINDOW_MSG    = 4'd4;
   localparam logic [31:0] TIMER_MESSAGE_CODE = 32'h0000_0113;

   localparam logic CMD_PUT = 1'b0;
   localparam logic CMD_GET = 1'b1;

   localparam logic [2:0] ST_QUEUED      = 3'd0;
   localparam logic [2:0] ST_DUPLICATE   = 3'd1;
   localparam logic [2:0] ST_NOT_ENABLED = 3'd2;
   localparam logic [2:0] ST_DELIVERED   = 3'd3;
   localparam logic [2:0] ST_EMPTY_IDLE  = 3'd4;
   localparam logic [2:0] ST_FULL        = 3'd5;

   typedef struct packed {
      logic        command;
      logic [3:0]  event_code;
      logic [31:0] message_id;
      logic [31:0] window_handle;
      logic [31:0] word_param;
      logic [31:0] long_param;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  out_event_code;
      logic [31:0] out_message_id;
      logic [31:0] out_window_handle;
      logic [31:0] out_word_param;
      logic [31:0] out_long_param;
      logic [31:0] out_entry_number;
      logic [4:0]  queue_count;
      logic [4:0]  pending_window_msgs;
      logic [31:0] total_requests;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] message;
      logic [31:0] window;
      logic [31:0] wparam;
      logic [31:0] lparam;
      logic [31:0] number;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage
`default_nettype wire

@@ design/tlrpq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tlrpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

@@ design/two_level_request_priority_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel    | ports                                   | transfer
// request    | start, busy, req_data                   | start && !busy
// result     | rsp_valid, rsp_data                     | rsp_valid (one cycle)
// config     | psel penable pwrite paddr pwdata prdata | psel && penable && pready
// A get passes through S_GET: one registered read of the entry memory.
// A put passes through S_PUT. A window message first scans the queued
// normal-level entries for a duplicate timer, reading one entry per
// S_SCAN_RD/S_SCAN_CHK pass; a shutdown adds S_PUT2 (second write).
// A put while disabled is answered from S_IDLE.
// Reset is synchronous; the entry memory is not cleared, head/tail/counts are.
// The result is a one-cycle strobe; the next request may be taken in that cycle.
module two_level_request_priority_queue
   import tlrpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  wire logic    psel,
   input  wire logic    penable,
   input  wire logic    pwrite,
   input  wire logic    paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int MD = 2 * QUEUE_DEPTH;
   localparam int AW = $clog2(MD);

   typedef enum logic [2:0] {
      S_IDLE, S_GET, S_SCAN_RD, S_SCAN_CHK, S_PUT, S_PUT2
   } state_type;

   state_type     state_ff;
   req_type       req_ff;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;
   logic          enable_ff;
   logic [PW-1:0] head_n_ff, tail_n_ff, head_i_ff, tail_i_ff;
   logic [CW-1:0] count_n_ff, count_i_ff, wmsg_ff, idx_ff;
   logic [31:0]   arrival_ff;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type     rd_entry, wr_entry;
   logic [PW:0]   scan_sum;
   logic [PW-1:0] scan_ptr;
   logic [CW:0]   held;
   logic          is_idle_kind;

   assign rd_entry     = entry_type'(ram_rdata);
   assign is_idle_kind = (req_ff.event_code == KIND_IDLE);
   assign held         = (CW+1)'(count_n_ff) + (CW+1)'(count_i_ff);

   assign scan_sum = (PW+1)'(head_n_ff) + (PW+1)'(idx_ff);
   assign scan_ptr = (scan_sum >= (PW+1)'(QUEUE_DEPTH))
                   ? PW'(scan_sum - (PW+1)'(QUEUE_DEPTH)) : PW'(scan_sum);

   always_comb begin
      if (state_ff == S_SCAN_RD) begin
         ram_raddr = AW'(scan_ptr);
      end else if (count_n_ff != '0) begin
         ram_raddr = AW'(head_n_ff);
      end else begin
         ram_raddr = AW'(head_i_ff) + AW'(QUEUE_DEPTH);
      end
      ram_waddr = is_idle_kind ? AW'(tail_i_ff) + AW'(QUEUE_DEPTH) : AW'(tail_n_ff);
      ram_we    = (state_ff == S_PUT2) ||
                  ((state_ff == S_PUT) &&
                   (held + ((req_ff.event_code == KIND_SHUTDOWN) ? (CW+1)'(2) : (CW+1)'(1))
                    <= (CW+1)'(QUEUE_DEPTH)));
      wr_entry.kind    = req_ff.event_code;
      wr_entry.message = req_ff.message_id;
      wr_entry.window  = req_ff.window_handle;
      wr_entry.wparam  = req_ff.word_param;
      wr_entry.lparam  = req_ff.long_param;
      wr_entry.number  = arrival_ff + 32'd1;
   end

   tlrpq_ram #(.WIDTH(ENTRY_W), .DEPTH(MD)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (wr_entry),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin : fsm
      logic [CW:0] held_new;
      logic [CW-1:0] wmsg_new;
      logic [CW-1:0] cn_new, ci_new;
      logic [31:0] arr_new;
      logic [2:0]  st;
      logic        done;
      entry_type   outv;

      held_new = held;
      wmsg_new = wmsg_ff;
      cn_new   = count_n_ff;
      ci_new   = count_i_ff;
      arr_new  = arrival_ff;
      st       = ST_QUEUED;
      done     = 1'b0;
      outv     = '0;

      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= 1'b0;
         head_n_ff    <= '0;
         tail_n_ff    <= '0;
         head_i_ff    <= '0;
         tail_i_ff    <= '0;
         count_n_ff   <= '0;
         count_i_ff   <= '0;
         wmsg_ff      <= '0;
         arrival_ff   <= '0;
         idx_ff       <= '0;
      end else begin
         if (psel && penable && pwrite && !paddr) begin
            enable_ff <= pwdata[0];
         end

         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff <= req_data;
                  if (req_data.command == CMD_GET) begin
                     state_ff <= S_GET;
                  end else if (!enable_ff) begin
                     st   = ST_NOT_ENABLED;
                     done = 1'b1;
                  end else if (req_data.event_code == KIND_WINDOW_MSG && count_n_ff != '0) begin
                     idx_ff   <= '0;
                     state_ff <= S_SCAN_RD;
                  end else begin
                     state_ff <= S_PUT;
                  end
               end
            end
            S_GET: begin
               done = 1'b1;
               if (held == '0) begin
                  st = ST_EMPTY_IDLE;
               end else begin
                  st   = ST_DELIVERED;
                  outv = rd_entry;
                  if (rd_entry.kind == KIND_WINDOW_MSG && wmsg_ff != '0) begin
                     wmsg_new = wmsg_ff - 1'b1;
                  end
                  if (count_n_ff != '0) begin
                     cn_new    = count_n_ff - 1'b1;
                     head_n_ff <= (head_n_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : head_n_ff + 1'b1;
                  end else begin
                     ci_new    = count_i_ff - 1'b1;
                     head_i_ff <= (head_i_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : head_i_ff + 1'b1;
                  end
               end
            end
            S_SCAN_RD: begin
               state_ff <= S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
               if (rd_entry.kind == KIND_WINDOW_MSG &&
                   rd_entry.message == TIMER_MESSAGE_CODE &&
                   rd_entry.window == req_ff.window_handle &&
                   rd_entry.wparam == req_ff.word_param &&
                   rd_entry.lparam == req_ff.long_param) begin
                  st   = ST_DUPLICATE;
                  done = 1'b1;
               end else if (idx_ff + 1'b1 == count_n_ff) begin
                  state_ff <= S_PUT;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_SCAN_RD;
               end
            end
            S_PUT: begin
               if (!ram_we) begin
                  st   = ST_FULL;
                  done = 1'b1;
               end else begin
                  arr_new = arrival_ff + 32'd1;
                  if (req_ff.event_code == KIND_WINDOW_MSG) begin
                     wmsg_new = wmsg_ff + 1'b1;
                  end
                  if (is_idle_kind) begin
                     ci_new    = count_i_ff + 1'b1;
                     tail_i_ff <= (tail_i_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_i_ff + 1'b1;
                  end else begin
                     cn_new    = count_n_ff + 1'b1;
                     tail_n_ff <= (tail_n_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_n_ff + 1'b1;
                  end
                  if (req_ff.event_code == KIND_SHUTDOWN) begin
                     state_ff <= S_PUT2;
                  end else begin
                     done = 1'b1;
                  end
               end
            end
            S_PUT2: begin
               arr_new   = arrival_ff + 32'd1;
               cn_new    = count_n_ff + 1'b1;
               tail_n_ff <= (tail_n_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_n_ff + 1'b1;
               done      = 1'b1;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         held_new   = (CW+1)'(cn_new) + (CW+1)'(ci_new);
         count_n_ff <= cn_new;
         count_i_ff <= ci_new;
         wmsg_ff    <= wmsg_new;
         arrival_ff <= arr_new;

         rsp_valid_ff <= done;
         if (done) begin
            state_ff                   <= S_IDLE;
            rsp_ff.status              <= st;
            rsp_ff.out_event_code      <= outv.kind;
            rsp_ff.out_message_id      <= outv.message;
            rsp_ff.out_window_handle   <= outv.window;
            rsp_ff.out_word_param      <= outv.wparam;
            rsp_ff.out_long_param      <= outv.lparam;
            rsp_ff.out_entry_number    <= outv.number;
            rsp_ff.queue_count         <= 5'(held_new);
            rsp_ff.pending_window_msgs <= 5'(wmsg_new);
            rsp_ff.total_requests      <= arr_new;
         end
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign prdata    = paddr ? 32'd0 : {31'd0, enable_ff};
   assign pready    = 1'b1;

endmodule
`default_nettype wire

@@ design/tlrpq_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tlrpq_checker
   import tlrpq_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid)) else $error("transfer neither raised busy nor answered");

   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid) else $error("busy fell without result");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !(start && !busy)) |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status <= ST_FULL)) else $error("bad status");

endmodule

bind two_level_request_priority_queue tlrpq_checker u_tlrpq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire
